FILE: design/multi_format_saturating_mixer_assert.svh
// ----------------------------------------------------------------------------
// Mixer assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTI_FORMAT_SATURATING_MIXER_ASSERT_SVH
`define MULTI_FORMAT_SATURATING_MIXER_ASSERT_SVH

`ifndef SYNTHESIS

`define MFSM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

`define MFSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MFSM_ASSERT(lbl, clk, rstn, prop, msg)

`define MFSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: design/mfsm_pkg.sv
// ----------------------------------------------------------------------------
// Mixer package
// Shared widths, format codes, register indexes and sample helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfsm_pkg;

    localparam int NUM_STREAMS = 8;
    localparam int LANE_W      = 32;
    localparam int SUM_W       = LANE_W + $clog2(NUM_STREAMS) + 1;
    localparam int CNT_W       = 4;
    localparam int FMT_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;

    localparam int U8_BITS  = 8;
    localparam int S16_BITS = 16;
    localparam int S24_BITS = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_STREAMS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT  = CFG_IDX_W'(1);

    localparam logic [CNT_W-1:0] ACTIVE_STREAMS_RESET = CNT_W'(1);

    typedef enum logic [FMT_W-1:0] {
        FMT_U8  = 2'd0,
        FMT_S16 = 2'd1,
        FMT_S24 = 2'd2,
        FMT_S32 = 2'd3
    } fmt_t;

    typedef logic signed [LANE_W-1:0] dec_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef dec_t dec_lanes_t [NUM_STREAMS];

    typedef struct packed {
        logic valid;
        fmt_t fmt;
    } stage_ctrl_t;

    localparam sum_t U8_MAX  = sum_t'(2 ** (U8_BITS - 1) - 1);
    localparam sum_t S16_MAX = sum_t'(2 ** (S16_BITS - 1) - 1);
    localparam sum_t S24_MAX = sum_t'(2 ** (S24_BITS - 1) - 1);
    localparam sum_t S32_MAX = sum_t'(2 ** (LANE_W - 1) - 1);

    // Offset binary becomes two's complement by inverting the top bit.
    function automatic dec_t decode_lane(logic [LANE_W-1:0] raw, fmt_t f);
        dec_t v;
        unique case (f)
            FMT_U8:  v = {{(LANE_W - U8_BITS + 1){~raw[U8_BITS-1]}}, raw[U8_BITS-2:0]};
            FMT_S16: v = {{(LANE_W - S16_BITS){raw[S16_BITS-1]}}, raw[S16_BITS-1:0]};
            FMT_S24: v = {{(LANE_W - S24_BITS){raw[S24_BITS-1]}}, raw[S24_BITS-1:0]};
            FMT_S32: v = raw;
        endcase
        return v;
    endfunction

    function automatic sum_t fmt_max(fmt_t f);
        sum_t m;
        unique case (f)
            FMT_U8:  m = U8_MAX;
            FMT_S16: m = S16_MAX;
            FMT_S24: m = S24_MAX;
            FMT_S32: m = S32_MAX;
        endcase
        return m;
    endfunction

    function automatic logic [LANE_W-1:0] encode_sample(sum_t v, fmt_t f);
        logic [LANE_W-1:0] e;
        unique case (f)
            FMT_U8:  e = {{(LANE_W - U8_BITS){1'b0}}, ~v[U8_BITS-1], v[U8_BITS-2:0]};
            FMT_S16: e = {{(LANE_W - S16_BITS){1'b0}}, v[S16_BITS-1:0]};
            FMT_S24: e = {{(LANE_W - S24_BITS){1'b0}}, v[S24_BITS-1:0]};
            FMT_S32: e = v[LANE_W-1:0];
        endcase
        return e;
    endfunction

endpackage

FILE: design/mfsm_decode.sv
// ----------------------------------------------------------------------------
// Mixer lane decoder
// Registers the incoming request with active lanes decoded to two's complement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfsm_decode (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    input  logic [mfsm_pkg::NUM_STREAMS*mfsm_pkg::LANE_W-1:0] in_data,
    input  logic [mfsm_pkg::CNT_W-1:0]                     active_streams,
    input  mfsm_pkg::fmt_t                                 sample_format,
    output mfsm_pkg::stage_ctrl_t                          out_ctrl,
    input  logic                                           out_ready,
    output mfsm_pkg::dec_lanes_t                           out_lanes
);

    import mfsm_pkg::*;

    logic       valid_reg;
    fmt_t       fmt_reg;
    dec_lanes_t lanes_reg;
    dec_lanes_t lanes_next;

    assign in_ready = !valid_reg || out_ready;

    // Lanes beyond the active count contribute zero to the sum.
    always_comb
    begin
        for (int i = 0; i < NUM_STREAMS; i++)
        begin
            if (CNT_W'(i) < active_streams)
            begin
                lanes_next[i] = decode_lane(in_data[i*LANE_W +: LANE_W], sample_format);
            end
            else
            begin
                lanes_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            lanes_reg <= lanes_next;
            fmt_reg   <= sample_format;
        end
    end

    assign out_ctrl  = '{valid: valid_reg, fmt: fmt_reg};
    assign out_lanes = lanes_reg;

endmodule

FILE: design/mfsm_adder.sv
// ----------------------------------------------------------------------------
// Mixer adder
// Sums the decoded lanes at full width into the sum register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfsm_adder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mfsm_pkg::stage_ctrl_t in_ctrl,
    output logic                  in_ready,
    input  mfsm_pkg::dec_lanes_t  in_lanes,
    output mfsm_pkg::stage_ctrl_t out_ctrl,
    input  logic                  out_ready,
    output mfsm_pkg::sum_t        out_sum
);

    import mfsm_pkg::*;

    logic valid_reg;
    fmt_t fmt_reg;
    sum_t sum_reg;
    sum_t sum_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NUM_STREAMS; i++)
        begin
            sum_next = sum_next + SUM_W'(in_lanes[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_ctrl.valid)
        begin
            sum_reg <= sum_next;
            fmt_reg <= in_ctrl.fmt;
        end
    end

    assign out_ctrl = '{valid: valid_reg, fmt: fmt_reg};
    assign out_sum  = sum_reg;

endmodule

FILE: design/mfsm_clamp.sv
// ----------------------------------------------------------------------------
// Mixer clamp
// Saturates the sum to the format's range and re-encodes it into the result
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfsm_clamp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mfsm_pkg::stage_ctrl_t        in_ctrl,
    output logic                         in_ready,
    input  mfsm_pkg::sum_t               in_sum,
    output mfsm_pkg::stage_ctrl_t        out_ctrl,
    input  logic                         out_ready,
    output logic [mfsm_pkg::LANE_W-1:0]  out_data
);

    import mfsm_pkg::*;

    logic              valid_reg;
    fmt_t              fmt_reg;
    logic [LANE_W-1:0] data_reg;
    logic [LANE_W-1:0] data_next;
    sum_t              max_val;
    sum_t              min_val;
    sum_t              sat_val;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        max_val = fmt_max(in_ctrl.fmt);
        min_val = -max_val - sum_t'(1);
        priority if (in_sum > max_val)
        begin
            sat_val = max_val;
        end
        else if (in_sum < min_val)
        begin
            sat_val = min_val;
        end
        else
        begin
            sat_val = in_sum;
        end
        data_next = encode_sample(sat_val, in_ctrl.fmt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_ctrl.valid)
        begin
            data_reg <= data_next;
            fmt_reg  <= in_ctrl.fmt;
        end
    end

    assign out_ctrl = '{valid: valid_reg, fmt: fmt_reg};
    assign out_data = data_reg;

endmodule

FILE: design/multi_format_saturating_mixer.sv
// ----------------------------------------------------------------------------
// Multi-format saturating mixer
// An accepted request passes the decode, adder and clamp registers in order.
// Throughput: one request per cycle through the decode, add and clamp stages.
// A stalled output holds the pipeline; each stage refills as soon as it drains.
// Reset clears all stage valid flags and sets one active stream in S16 format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multi_format_saturating_mixer_assert.svh"

module multi_format_saturating_mixer (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              s_axis_tvalid,
    output logic                                              s_axis_tready,
    // lane_0, lane_1, ... lane_7, 32 bits each, lowest first.
    input  logic [mfsm_pkg::NUM_STREAMS*mfsm_pkg::LANE_W-1:0] s_axis_tdata,
    output logic                                              m_axis_tvalid,
    input  logic                                              m_axis_tready,
    // mixed_sample, 32 bits.
    output logic [mfsm_pkg::LANE_W-1:0]                       m_axis_tdata,
    input  logic                                              cfg_valid,
    output logic                                              cfg_ready,
    input  logic [mfsm_pkg::CFG_IDX_W-1:0]                    cfg_index,
    input  logic [mfsm_pkg::CFG_DATA_W-1:0]                   cfg_data
);

    import mfsm_pkg::*;

    logic [CNT_W-1:0] active_streams_reg;
    fmt_t             sample_format_reg;

    stage_ctrl_t dec_ctrl;
    dec_lanes_t  dec_lanes;
    logic        dec_ready;
    stage_ctrl_t add_ctrl;
    sum_t        add_sum;
    logic        add_ready;
    stage_ctrl_t res_ctrl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_streams_reg <= ACTIVE_STREAMS_RESET;
            sample_format_reg  <= FMT_S16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ACTIVE_STREAMS: active_streams_reg <= cfg_data[CNT_W-1:0];
                CFG_SAMPLE_FORMAT:  sample_format_reg  <= fmt_t'(cfg_data[FMT_W-1:0]);
                default:            ;
            endcase
        end
    end

    mfsm_decode u_decode (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_data        (s_axis_tdata),
        .active_streams (active_streams_reg),
        .sample_format  (sample_format_reg),
        .out_ctrl       (dec_ctrl),
        .out_ready      (dec_ready),
        .out_lanes      (dec_lanes)
    );

    mfsm_adder u_adder (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctrl   (dec_ctrl),
        .in_ready  (dec_ready),
        .in_lanes  (dec_lanes),
        .out_ctrl  (add_ctrl),
        .out_ready (add_ready),
        .out_sum   (add_sum)
    );

    mfsm_clamp u_clamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctrl   (add_ctrl),
        .in_ready  (add_ready),
        .in_sum    (add_sum),
        .out_ctrl  (res_ctrl),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    assign m_axis_tvalid = res_ctrl.valid;

    `MFSM_ASSERT_NEXT(a_accept_loads_decode, clk, rst_n, s_axis_tvalid && s_axis_tready, dec_ctrl.valid, "Accepted request did not reach the decode stage.")
    `MFSM_ASSERT_NEXT(a_decode_holds_on_stall, clk, rst_n, dec_ctrl.valid && !dec_ready, dec_ctrl.valid, "Decode stage dropped a stalled request.")
    `MFSM_ASSERT(a_u8_upper_zero, clk, rst_n, (res_ctrl.valid && res_ctrl.fmt == FMT_U8) |-> (m_axis_tdata[LANE_W-1:U8_BITS] == '0), "U8 result has upper bits set.")
    `MFSM_ASSERT(a_s16_upper_zero, clk, rst_n, (res_ctrl.valid && res_ctrl.fmt == FMT_S16) |-> (m_axis_tdata[LANE_W-1:S16_BITS] == '0), "S16 result has upper bits set.")
    `MFSM_ASSERT(a_s24_upper_zero, clk, rst_n, (res_ctrl.valid && res_ctrl.fmt == FMT_S24) |-> (m_axis_tdata[LANE_W-1:S24_BITS] == '0), "S24 result has upper bits set.")

endmodule
